// ----- rtl/core/acc_cpu_pkg.sv -----
// package: shared constants and types for the accumulator cpu core
`default_nettype none
package acc_cpu_pkg;
  localparam int unsigned MemWords = 1024;
  localparam int unsigned MemAw = $clog2(MemWords);

  localparam logic [1:0] ActWrite = 2'd0;
  localparam logic [1:0] ActRead  = 2'd1;
  localparam logic [1:0] ActExec  = 2'd2;

  localparam logic [1:0] StOk     = 2'd0;
  localparam logic [1:0] StHalted = 2'd1;
  localparam logic [1:0] StBranch = 2'd2;
  localparam logic [1:0] StDivZero = 2'd3;

  localparam logic [1:0] ModeDirect = 2'd0;
  localparam logic [1:0] ModeImm    = 2'd1;
  localparam logic [1:0] ModeIndex  = 2'd2;
  localparam logic [1:0] ModeInd    = 2'd3;

  localparam logic [3:0] OpHalt  = 4'd0;
  localparam logic [3:0] OpLoad  = 4'd1;
  localparam logic [3:0] OpStore = 4'd2;
  localparam logic [3:0] OpCall  = 4'd3;
  localparam logic [3:0] OpBr    = 4'd4;
  localparam logic [3:0] OpBreq  = 4'd5;
  localparam logic [3:0] OpBrge  = 4'd6;
  localparam logic [3:0] OpBrlt  = 4'd7;
  localparam logic [3:0] OpAdd   = 4'd8;
  localparam logic [3:0] OpSub   = 4'd9;
  localparam logic [3:0] OpMul   = 4'd10;
  localparam logic [3:0] OpDiv   = 4'd11;

  // memory address source
  typedef enum logic [2:0] {
    ASelIn  = 3'b001,
    ASelPc  = 3'b010,
    ASelEa  = 3'b100
  } asel_e;

  typedef struct packed {
    logic  take_item;   // latch input item
    logic  mem_re;
    logic  mem_we;
    asel_e asel;
    logic  wsel_acc;    // write data: acc, pc + 1, else input data
    logic  wsel_pc;
    logic  load_ir;
    logic  load_ptr;    // ea from pointer word
    logic  load_opnd;
    logic  exec;        // apply instruction result
    logic  div_start;
    logic  rd_capture;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       halted;
    logic [3:0] opcode;
    logic [1:0] mode;
    logic       div_busy;
  } stat_t;
endpackage
`default_nettype wire

// ----- rtl/core/acc_cpu_ram.sv -----
// generic single port ram with registered read
`default_nettype none
module acc_cpu_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/acc_cpu_div.sv -----
// iterative 16-bit unsigned restoring divider, one bit per cycle
`default_nettype none
module acc_cpu_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [15:0] dividend_i,
  input  wire logic [15:0] divisor_i,
  output logic             busy_o,
  output logic      [15:0] quot_o
);
  logic [4:0]  cnt_q, cnt_d;
  logic [15:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic [16:0] trial;

  always_comb begin
    cnt_d = cnt_q;
    rem_d = rem_q;
    quo_d = quo_q;
    dvs_d = dvs_q;
    trial = {rem_q, quo_q[15]} - {1'b0, dvs_q};
    if (start_i) begin
      cnt_d = 5'd16;
      rem_d = '0;
      quo_d = dividend_i;
      dvs_d = divisor_i;
    end else if (cnt_q != 5'd0) begin
      cnt_d = cnt_q - 5'd1;
      if (!trial[16]) begin
        rem_d = trial[15:0];
        quo_d = {quo_q[14:0], 1'b1};
      end else begin
        rem_d = {rem_q[14:0], quo_q[15]};
        quo_d = {quo_q[14:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = (cnt_q != 5'd0);
  assign quot_o = quo_q;
endmodule
`default_nettype wire

// ----- rtl/core/acc_cpu_dp.sv -----
// datapath: registers, memory, alu and output register
`default_nettype none
module acc_cpu_dp (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire acc_cpu_pkg::cmd_t    cmd_i,
  output acc_cpu_pkg::stat_t        stat_o,
  input  wire logic [1:0]           action_i,
  input  wire logic [9:0]           mem_addr_i,
  input  wire logic [15:0]          mem_data_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [9:0]           cfg_wdata_i,
  output logic      [47:0]          out_data_o
);
  localparam int unsigned Aw = acc_cpu_pkg::MemAw;

  logic [9:0]  pc_q, pc_d, ea_q, ea_d, ib_q, addr_in_q;
  logic [15:0] acc_q, acc_d, data_in_q, ir_q, opnd_q, rd_q, mem_rdata, mem_wdata;
  logic [1:0]  act_q, st_d;
  logic        halt_q, halt_d;
  logic [47:0] out_q;
  logic [9:0]  mem_a10;
  logic [15:0] mul_q, quot;
  logic        div_busy;
  logic [3:0]  op;
  logic [1:0]  md;

  assign op = ir_q[15:12];
  assign md = ir_q[11:10];

  always_comb begin
    unique case (cmd_i.asel)
      acc_cpu_pkg::ASelIn: mem_a10 = addr_in_q;
      acc_cpu_pkg::ASelPc: mem_a10 = pc_q;
      acc_cpu_pkg::ASelEa: mem_a10 = ea_q;
      default:             mem_a10 = ea_q;
    endcase
    if (cmd_i.wsel_acc) begin
      mem_wdata = acc_q;
    end else if (cmd_i.wsel_pc) begin
      mem_wdata = {6'd0, pc_q + 10'd1};
    end else begin
      mem_wdata = data_in_q;
    end
  end

  acc_cpu_ram #(.Width(16), .Depth(acc_cpu_pkg::MemWords)) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.mem_we),
    .re_i    (cmd_i.mem_re),
    .addr_i  (mem_a10[Aw-1:0]),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  acc_cpu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (acc_q),
    .divisor_i  (opnd_q),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  always_comb begin
    ea_d = ea_q;
    if (cmd_i.load_ir) begin
      if (mem_rdata[11:10] == acc_cpu_pkg::ModeIndex) begin
        ea_d = mem_rdata[9:0] + ib_q;
      end else begin
        ea_d = mem_rdata[9:0];
      end
    end else if (cmd_i.load_ptr) begin
      ea_d = mem_rdata[9:0];
    end
  end

  always_comb begin
    pc_d = pc_q;
    acc_d = acc_q;
    halt_d = halt_q;
    st_d = halt_q ? acc_cpu_pkg::StHalted : acc_cpu_pkg::StOk;
    if (cmd_i.exec) begin
      pc_d = pc_q + 10'd1;
      st_d = acc_cpu_pkg::StOk;
      case (op) inside
        acc_cpu_pkg::OpHalt: begin
          halt_d = 1'b1;
          st_d = acc_cpu_pkg::StHalted;
        end
        acc_cpu_pkg::OpLoad:  acc_d = opnd_q;
        acc_cpu_pkg::OpCall:  pc_d = ea_q + 10'd1;
        acc_cpu_pkg::OpBr:    pc_d = ea_q;
        acc_cpu_pkg::OpBreq:  if (acc_q == 16'd0) pc_d = ea_q;
        acc_cpu_pkg::OpBrge, acc_cpu_pkg::OpBrlt: st_d = acc_cpu_pkg::StBranch;
        acc_cpu_pkg::OpAdd:   acc_d = acc_q + opnd_q;
        acc_cpu_pkg::OpSub:   acc_d = acc_q - opnd_q;
        acc_cpu_pkg::OpMul:   acc_d = mul_q;
        acc_cpu_pkg::OpDiv: begin
          if (opnd_q == 16'd0) begin
            st_d = acc_cpu_pkg::StDivZero;
          end else begin
            acc_d = quot;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= '0;
      acc_q  <= '0;
      halt_q <= 1'b0;
      ib_q   <= '0;
    end else begin
      if (cfg_we_i) ib_q <= cfg_wdata_i;
      if (cmd_i.exec) begin
        pc_q   <= pc_d;
        acc_q  <= acc_d;
        halt_q <= halt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item) begin
      act_q     <= action_i;
      addr_in_q <= mem_addr_i;
      data_in_q <= mem_data_i;
    end
    if (cmd_i.load_ir) ir_q <= mem_rdata;
    ea_q <= ea_d;
    if (cmd_i.load_opnd) begin
      opnd_q <= (md == acc_cpu_pkg::ModeImm) ? {6'd0, ir_q[9:0]} : mem_rdata;
    end
    mul_q <= acc_q * opnd_q;
    if (cmd_i.take_item) begin
      rd_q <= '0;
    end else if (cmd_i.rd_capture) begin
      rd_q <= mem_rdata;
    end
    if (cmd_i.out_load) begin
      out_q <= {(cmd_i.exec ? op : 4'd0), rd_q, acc_d, pc_d, st_d};
    end
  end

  assign out_data_o = out_q;
  assign stat_o = '{action: act_q, halted: halt_q, opcode: op, mode: md,
                    div_busy: div_busy};
endmodule
`default_nettype wire

// ----- rtl/core/acc_cpu_ctrl.sv -----
// controller: sequences memory actions and instruction execution
`default_nettype none
module acc_cpu_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_tvalid_i,
  output logic                    s_tready_o,
  output logic                    m_tvalid_o,
  input  wire logic               m_tready_i,
  input  wire acc_cpu_pkg::stat_t stat_i,
  output acc_cpu_pkg::cmd_t       cmd_o
);
  typedef enum logic [10:0] {
    SIdle   = 11'b00000000001,
    SDecode = 11'b00000000010,
    SRdWait = 11'b00000000100,
    SFetch  = 11'b00000001000,
    SIr     = 11'b00000010000,
    SPtr    = 11'b00000100000,
    SOpRd   = 11'b00001000000,
    SOpnd   = 11'b00010000000,
    SArith  = 11'b00100000000,
    SDiv    = 11'b01000000000,
    SExec   = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  logic   out_v_q, out_v_d, finish;
  logic   can_take;

  assign can_take   = !out_v_q || m_tready_i;
  assign s_tready_o = (state_q == SIdle);
  assign m_tvalid_o = out_v_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.asel = acc_cpu_pkg::ASelEa;
    state_d = state_q;
    finish = 1'b0;
    unique case (state_q)
      SIdle: begin
        if (s_tvalid_i && s_tready_o) begin
          cmd_o.take_item = 1'b1;
          state_d = SDecode;
        end
      end
      SDecode: begin
        cmd_o.asel = acc_cpu_pkg::ASelIn;
        if (stat_i.action == acc_cpu_pkg::ActWrite) begin
          cmd_o.mem_we = 1'b1;
          finish = 1'b1;
        end else if (stat_i.action == acc_cpu_pkg::ActRead) begin
          cmd_o.mem_re = 1'b1;
          state_d = SRdWait;
        end else if (stat_i.action == acc_cpu_pkg::ActExec && !stat_i.halted) begin
          state_d = SFetch;
        end else begin
          finish = 1'b1;
        end
      end
      SRdWait: begin
        cmd_o.rd_capture = 1'b1;
        state_d = SExec;
      end
      SFetch: begin
        cmd_o.asel = acc_cpu_pkg::ASelPc;
        cmd_o.mem_re = 1'b1;
        state_d = SIr;
      end
      SIr: begin
        cmd_o.load_ir = 1'b1;
        state_d = SPtr;
      end
      SPtr: begin
        if (stat_i.mode == acc_cpu_pkg::ModeInd) begin
          cmd_o.mem_re = 1'b1;
          state_d = SOpRd;
        end else begin
          state_d = SOpnd;
        end
      end
      SOpRd: begin
        cmd_o.load_ptr = 1'b1;
        state_d = SOpnd;
      end
      SOpnd: begin
        cmd_o.mem_re = 1'b1;
        if (stat_i.opcode == acc_cpu_pkg::OpStore) begin
          cmd_o.mem_re = 1'b0;
          cmd_o.mem_we = 1'b1;
          cmd_o.wsel_acc = 1'b1;
        end else if (stat_i.opcode == acc_cpu_pkg::OpCall) begin
          cmd_o.mem_re = 1'b0;
          cmd_o.mem_we = 1'b1;
          cmd_o.wsel_pc = 1'b1;
        end
        state_d = SArith;
      end
      SArith: begin
        cmd_o.load_opnd = 1'b1;
        state_d = SDiv;
      end
      SDiv: begin
        if (stat_i.opcode == acc_cpu_pkg::OpDiv) begin
          cmd_o.div_start = 1'b1;
        end
        state_d = SExec;
      end
      SExec: begin
        if (!stat_i.div_busy && can_take) begin
          finish = 1'b1;
          cmd_o.exec = (stat_i.action == acc_cpu_pkg::ActExec);
        end
      end
      default: state_d = SIdle;
    endcase
    if (finish && can_take) begin
      cmd_o.out_load = 1'b1;
      state_d = SIdle;
    end else if (finish) begin
      cmd_o.mem_we = 1'b0;
      cmd_o.mem_re = 1'b0;
    end
    out_v_d = out_v_q;
    if (m_tready_i) out_v_d = 1'b0;
    if (cmd_o.out_load) out_v_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_v_q <= out_v_d;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/accumulator_cpu_core.sv -----
// top level: accumulator cpu core, controller plus datapath
// throughput: one item at a time, next item taken the cycle after the result loads
// one output register lets the next item be taken while a result waits
// reset: asynchronous active low clears pc, accumulator, halt flag and index base
// memory contents are undefined until written; no clearing pass
`default_nettype none
module accumulator_cpu_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // action, mem_addr, mem_data, pad
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [47:0] m_axis_tdata,  // status, prog_counter, accumulator,
                                          // read_word, opcode_done
  input  wire logic        cfg_we,
  input  wire logic [9:0]  cfg_wdata
);
  acc_cpu_pkg::cmd_t  cmd;
  acc_cpu_pkg::stat_t stat;

  acc_cpu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  acc_cpu_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .action_i    (s_axis_tdata[1:0]),
    .mem_addr_i  (s_axis_tdata[11:2]),
    .mem_data_i  (s_axis_tdata[27:12]),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .out_data_o  (m_axis_tdata)
  );
endmodule
`default_nettype wire

// ----- rtl/core/acc_cpu_chk.sv -----
// port checker for the accumulator cpu core, bound to the top level
`default_nettype none
module acc_cpu_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("item taken while busy");
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result with no latency");
  a_halt_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2+10+16+16+:4] == 4'd0 && m_axis_tdata[1:0] == 2'd2
    |-> 1'b0)
    else $error("branch flag without opcode");
endmodule

bind accumulator_cpu_core acc_cpu_chk u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

// ----- bench/tb_top.sv -----
// testbench for the accumulator cpu core: predicts every result and checks it in order
`timescale 1ns / 100ps
module tb_top;
  import acc_cpu_pkg::*;

  localparam int unsigned CycleLimit = 1500000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned ItemTarget = 1850;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [15:0] rword;
    logic [15:0] acc;
    logic [9:0]  pc;
    logic [1:0]  status;
  } cpu_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        cfg_we = 1'b0;
  logic [9:0]  cfg_wdata = '0;

  // cpu state as the core should hold it
  logic [15:0] shadow_mem [MemWords];
  logic [9:0]  shadow_pc = '0;
  logic [15:0] shadow_acc = '0;
  logic        shadow_halted = 1'b0;
  logic [9:0]  shadow_index = '0;

  cpu_result_t pending_results[$];
  int unsigned items_sent = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned hold_cycles = 0;
  bit          quiet_links = 1'b0;

  accumulator_cpu_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[accumulator_cpu_core] ERROR");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    if (quiet_links) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 3);
  endfunction

  // receiver side: random stalls plus long hold-offs, at random or on request
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (quiet_links) begin
      m_axis_tready <= 1'b1;
    end else if ($urandom_range(0, 39) == 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles <= $urandom_range(10, 50);
    end else begin
      m_axis_tready <= ($urandom_range(0, 2) != 0);
    end
  end

  task automatic step_shadow(input logic [1:0] act, input logic [9:0] addr,
                             input logic [15:0] data, output cpu_result_t res);
    logic [15:0] ir;
    logic [15:0] opnd;
    logic [3:0]  op;
    logic [1:0]  md;
    logic [9:0]  fld;
    logic [9:0]  ea;
    res = '0;
    res.status = shadow_halted ? StHalted : StOk;
    if (act == ActWrite) begin
      shadow_mem[addr] = data;
    end else if (act == ActRead) begin
      res.rword = shadow_mem[addr];
    end else if (act == ActExec && !shadow_halted) begin
      ir = shadow_mem[shadow_pc];
      op = ir[15:12];
      md = ir[11:10];
      fld = ir[9:0];
      ea = fld;
      if (md == ModeIndex) ea = fld + shadow_index;
      else if (md == ModeInd) ea = shadow_mem[fld][9:0];
      shadow_pc = shadow_pc + 10'd1;
      res.opcode = op;
      opnd = (md == ModeImm) ? {6'd0, fld} : shadow_mem[ea];
      case (op)
        OpHalt: begin
          shadow_halted = 1'b1;
          res.status = StHalted;
        end
        OpLoad:  shadow_acc = opnd;
        OpStore: shadow_mem[ea] = shadow_acc;
        OpCall: begin
          shadow_mem[ea] = {6'd0, shadow_pc};
          shadow_pc = ea + 10'd1;
        end
        OpBr:    shadow_pc = ea;
        OpBreq:  if (shadow_acc == 16'd0) shadow_pc = ea;
        OpBrge, OpBrlt: res.status = StBranch;
        OpAdd:   shadow_acc = shadow_acc + opnd;
        OpSub:   shadow_acc = shadow_acc - opnd;
        OpMul:   shadow_acc = shadow_acc * opnd;
        OpDiv: begin
          if (opnd == 16'd0) res.status = StDivZero;
          else shadow_acc = shadow_acc / opnd;
        end
        default: ;
      endcase
    end
    res.pc = shadow_pc;
    res.acc = shadow_acc;
  endtask

  task automatic send_item(input logic [1:0] act, input logic [9:0] addr,
                           input logic [15:0] data);
    int unsigned gap;
    cpu_result_t res;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {4'd0, data, addr, act};
    do @(posedge clk_i); while (!s_axis_tready);
    step_shadow(act, addr, data, res);
    pending_results.push_back(res);
    items_sent++;
  endtask

  task automatic run_instr(input logic [3:0] op, input logic [1:0] md, input logic [9:0] fld);
    send_item(ActWrite, shadow_pc, {op, md, fld});
    send_item(ActExec, 10'($urandom), 16'($urandom));
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_index(input logic [9:0] value);
    wait_idle();
    @(negedge clk_i);
    cfg_we = 1'b1;
    cfg_wdata = value;
    @(negedge clk_i);
    cfg_we = 1'b0;
    shadow_index = value;
  endtask

  // checker
  always @(posedge clk_i) begin
    cpu_result_t got;
    cpu_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.pc !== want.pc || got.acc !== want.acc ||
            got.rword !== want.rword || got.opcode !== want.opcode) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: status %0d/%0d pc %h/%h acc %h/%h rd %h/%h op %0d/%0d",
                     want.status, got.status, want.pc, got.pc, want.acc, got.acc,
                     want.rword, got.rword, want.opcode, got.opcode);
        end
      end
    end
  end

  task automatic test_fill_memory();
    for (int i = 0; i < MemWords; i++) send_item(ActWrite, 10'(i), 16'($urandom));
  endtask

  task automatic test_directed();
    send_item(ActWrite, 10'd1023, 16'hFFFF);
    send_item(ActRead, 10'd1023, 16'h0000);
    send_item(ActRead, 10'd0, 16'hFFFF);
    send_item(2'd3, 10'h3FF, 16'hFFFF);
    run_instr(OpLoad, ModeImm, 10'h3FF);
    run_instr(OpMul, ModeDirect, 10'd1023);
    run_instr(OpSub, ModeImm, 10'h3FF);
    run_instr(OpAdd, ModeIndex, 10'h3FF);
    run_instr(OpDiv, ModeImm, 10'd0);
    run_instr(OpDiv, ModeImm, 10'd3);
    run_instr(OpStore, ModeIndex, 10'd200);
    run_instr(OpLoad, ModeImm, 10'd0);
    run_instr(OpBreq, ModeDirect, 10'd300);
    run_instr(OpCall, ModeInd, 10'd1023);
    run_instr(OpBr, ModeImm, 10'd500);
    run_instr(OpBrge, ModeDirect, 10'd10);
    run_instr(OpBrlt, ModeIndex, 10'd10);
    for (int op = 12; op < 16; op++) run_instr(4'(op), ModeInd, 10'($urandom));
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    for (int i = 0; i < 20; i++) run_instr(4'($urandom_range(1, 15)), 2'($urandom), 10'($urandom));
  endtask

  task automatic test_random_phase(input int unsigned stop_at);
    int unsigned kind;
    while (items_sent < stop_at) begin
      kind = $urandom_range(0, 19);
      if (kind < 3) send_item(ActWrite, 10'($urandom), 16'($urandom));
      else if (kind < 5) send_item(ActRead, 10'($urandom), 16'($urandom));
      else if (kind == 5) send_item(2'd3, 10'($urandom), 16'($urandom));
      else if (kind < 9 && shadow_mem[shadow_pc][15:12] != OpHalt)
        send_item(ActExec, 10'($urandom), 16'($urandom));
      else run_instr(4'($urandom_range(1, 15)), 2'($urandom), 10'($urandom));
    end
  endtask

  task automatic test_halt();
    run_instr(OpHalt, 2'($urandom), 10'($urandom));
    send_item(ActExec, 10'($urandom), 16'($urandom));
    send_item(ActWrite, 10'd5, 16'h1234);
    send_item(ActRead, 10'd5, 16'd0);
    send_item(2'd3, 10'd0, 16'd0);
    send_item(ActExec, 10'd0, 16'd0);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    write_index(10'h3FF);
    quiet_links = 1'b1;
    test_fill_memory();
    quiet_links = 1'b0;
    test_directed();
    test_backpressure();
    write_index(10'd0);
    test_random_phase(1300);
    write_index(10'($urandom));
    quiet_links = 1'b1;
    test_random_phase(1500);
    quiet_links = 1'b0;
    write_index(10'h3FF);
    test_random_phase(ItemTarget);
    test_halt();
    wait_idle();
    if (mismatches == 0) begin
      $display("[accumulator_cpu_core] OK");
    end else begin
      $display("[accumulator_cpu_core] ERROR");
    end
    $finish;
  end
endmodule

// ----- files.f -----
rtl/core/acc_cpu_pkg.sv
rtl/core/acc_cpu_ram.sv
rtl/core/acc_cpu_div.sv
rtl/core/acc_cpu_dp.sv
rtl/core/acc_cpu_ctrl.sv
rtl/core/accumulator_cpu_core.sv
rtl/core/acc_cpu_chk.sv
bench/tb_top.sv
